/* hw/rtl/csms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant speed move step package
// Shared widths, register indexes, payload types and the control structs that
// run between the sequencer and the iterative root and divide unit.
// ----------------------------------------------------------------------------
package csms_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int SPEED_WIDTH    = 24;
    localparam int APB_ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;
    localparam int REG_IDX_WIDTH  = 3;

    localparam logic [REG_IDX_WIDTH-1:0] REG_START_X  = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_START_Y  = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_TARGET_X = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_TARGET_Y = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_SPEED_Q  = 3'd4;

    localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 24'd256;

    localparam logic ITER_SQRT = 1'b0;
    localparam logic ITER_DIV  = 1'b1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] cur_x;
        logic signed [COORD_WIDTH-1:0] cur_y;
    } csms_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] new_x;
        logic signed [COORD_WIDTH-1:0] new_y;
        logic                          moved;
        logic                          done_res;
    } csms_out_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] target_x;
        logic signed [COORD_WIDTH-1:0] target_y;
        logic        [SPEED_WIDTH-1:0] speed_q;
    } csms_cfg_t;

    typedef struct packed {
        logic start;
        logic mode;
    } iter_req_t;

    typedef struct packed {
        logic done;
    } iter_rsp_t;

endpackage

/* hw/rtl/csms_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant speed move step register file
// APB-style register bank for the start point, target point and speed, with a
// write strobe that tells the sequencer to clear its ended state.
// ----------------------------------------------------------------------------
module csms_cfg
    import csms_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    output csms_cfg_t                 cfg,
    output logic                      cfg_wr
);

    csms_cfg_t              cfg_reg;
    logic [REG_IDX_WIDTH-1:0] idx;

    assign idx    = paddr[APB_ADDR_WIDTH-1:2];
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x  <= '0;
            cfg_reg.start_y  <= '0;
            cfg_reg.target_x <= '0;
            cfg_reg.target_y <= '0;
            cfg_reg.speed_q  <= SPEED_RESET;
        end else if (cfg_wr) begin
            unique case (idx)
                REG_START_X:  cfg_reg.start_x  <= pwdata[COORD_WIDTH-1:0];
                REG_START_Y:  cfg_reg.start_y  <= pwdata[COORD_WIDTH-1:0];
                REG_TARGET_X: cfg_reg.target_x <= pwdata[COORD_WIDTH-1:0];
                REG_TARGET_Y: cfg_reg.target_y <= pwdata[COORD_WIDTH-1:0];
                REG_SPEED_Q:  cfg_reg.speed_q  <= pwdata[SPEED_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_START_X:  prdata = APB_DATA_WIDTH'(unsigned'(cfg_reg.start_x));
            REG_START_Y:  prdata = APB_DATA_WIDTH'(unsigned'(cfg_reg.start_y));
            REG_TARGET_X: prdata = APB_DATA_WIDTH'(unsigned'(cfg_reg.target_x));
            REG_TARGET_Y: prdata = APB_DATA_WIDTH'(unsigned'(cfg_reg.target_y));
            REG_SPEED_Q:  prdata = APB_DATA_WIDTH'(cfg_reg.speed_q);
            default:      prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/csms_iter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant speed move step root and divide unit
// One shared compare and subtract stage that runs either a restoring integer
// square root, two radicand bits a cycle, or a restoring divide, one bit a
// cycle.
// ----------------------------------------------------------------------------
module csms_iter
    import csms_pkg::*;
#(
    parameter int ROOT_W = 25,
    parameter int RAD_W  = 50,
    parameter int QUO_W  = 40
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  iter_req_t           req,
    input  logic [RAD_W-1:0]    radicand,
    input  logic [QUO_W-1:0]    dividend,
    input  logic [ROOT_W-1:0]   divisor,
    output iter_rsp_t           rsp,
    output logic [((RAD_W > QUO_W) ? RAD_W : QUO_W)-1:0] result
);

    localparam int SRC_W  = (RAD_W > QUO_W) ? RAD_W : QUO_W;
    localparam int UW     = ROOT_W + 2;
    localparam int STEPS  = (ROOT_W > QUO_W) ? ROOT_W : QUO_W;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              mode_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [UW-1:0]     rem_reg;
    logic [SRC_W-1:0]  src_reg;
    logic [SRC_W-1:0]  res_reg;

    logic [UW-1:0]     shifted;
    logic [UW-1:0]     trial;
    logic [UW:0]       diff;
    logic              ge;

    always_comb begin
        if (mode_reg == ITER_SQRT) begin
            shifted = {rem_reg[UW-3:0], src_reg[SRC_W-1 -: 2]};
            trial   = {res_reg[ROOT_W-1:0], 2'b01};
        end else begin
            shifted = {rem_reg[UW-2:0], src_reg[SRC_W-1]};
            trial   = {2'b00, divisor};
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = ~diff[UW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            mode_reg <= req.mode;
            rem_reg  <= '0;
            res_reg  <= '0;
            if (req.mode == ITER_SQRT) begin
                src_reg <= SRC_W'(radicand) << (SRC_W - RAD_W);
                cnt_reg <= STEP_W'(ROOT_W);
            end else begin
                src_reg <= SRC_W'(dividend) << (SRC_W - QUO_W);
                cnt_reg <= STEP_W'(QUO_W);
            end
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[UW-1:0] : shifted;
            res_reg <= {res_reg[SRC_W-2:0], ge};
            src_reg <= (mode_reg == ITER_SQRT) ? (src_reg << 2) : (src_reg << 1);
            cnt_reg <= cnt_reg - STEP_W'(1);
        end
    end

    assign rsp.done = done_reg;
    assign result   = res_reg;

endmodule

/* hw/rtl/constant_speed_move_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant speed move step
// Each step runs the bit-per-cycle root and two 40-bit divides in the shared
// unit. A tick after the move has ended goes straight to the output, and one
// at zero distance goes to the output after the root, with no divides.
// One transaction at a time; s_ready returns in the cycle after the result is
// loaded.
// Synchronous active-low reset clears the control and configuration registers,
// sets speed to 256 (1.0 at the default fraction bits) and clears ended.
// ----------------------------------------------------------------------------
module constant_speed_move_step
    import csms_pkg::*;
#(
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  csms_in_t                  s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output csms_out_t                 m_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    localparam int AW     = COORD_WIDTH;
    localparam int SW     = SPEED_WIDTH;
    localparam int PROD_W = AW + SW;
    localparam int D2W    = 2 * AW + 1;
    localparam int RAD_W  = 2 * AW + 2 + 2 * SPEED_FRAC_BITS;
    localparam int ROOT_W = RAD_W / 2;
    localparam int SRC_W  = (RAD_W > PROD_W) ? RAD_W : PROD_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SQX     = 4'd1;
    localparam logic [3:0] S_SQY     = 4'd2;
    localparam logic [3:0] S_SUM     = 4'd3;
    localparam logic [3:0] S_SQRT_GO = 4'd4;
    localparam logic [3:0] S_SQRT_WT = 4'd5;
    localparam logic [3:0] S_MX      = 4'd6;
    localparam logic [3:0] S_DX_GO   = 4'd7;
    localparam logic [3:0] S_DX_WT   = 4'd8;
    localparam logic [3:0] S_MY      = 4'd9;
    localparam logic [3:0] S_DY_GO   = 4'd10;
    localparam logic [3:0] S_DY_WT   = 4'd11;
    localparam logic [3:0] S_FIN     = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;

    localparam logic [1:0] KIND_SKIP = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_STEP = 2'd2;

    csms_cfg_t cfg;
    logic      cfg_wr;

    iter_req_t          iter_req;
    iter_rsp_t          iter_rsp;
    logic [SRC_W-1:0]   iter_result;

    logic [3:0]                state_reg, state_next;
    logic                      ended_reg;
    logic [1:0]                kind_reg;
    logic signed [AW-1:0]      cx_reg, cy_reg;
    logic                      negx_reg, negy_reg;
    logic [AW-1:0]             ax_reg, ay_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [D2W-1:0]            d2_reg;
    logic [ROOT_W-1:0]         dist_reg;
    logic [PROD_W-1:0]         qx_reg, qy_reg;
    logic signed [SUM_W-1:0]   sx_reg, sy_reg;
    logic                      m_valid_reg;
    csms_out_t                 m_data_reg;

    logic signed [AW:0]        dx, dy;
    logic [AW-1:0]             mul_a;
    logic [SW-1:0]             mul_b;
    logic signed [SUM_W-1:0]   lox, hix, loy, hiy;
    logic signed [AW-1:0]      nx, ny;
    logic                      out_load;
    csms_out_t                 out_data;
    logic                      ended_next;

    csms_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    csms_iter #(
        .ROOT_W (ROOT_W),
        .RAD_W  (RAD_W),
        .QUO_W  (PROD_W)
    ) u_iter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (iter_req),
        .radicand (RAD_W'(d2_reg) << (2 * SPEED_FRAC_BITS)),
        .dividend (prod_reg),
        .divisor  (dist_reg),
        .rsp      (iter_rsp),
        .result   (iter_result)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign dx = {cfg.target_x[AW-1], cfg.target_x} - {s_data.cur_x[AW-1], s_data.cur_x};
    assign dy = {cfg.target_y[AW-1], cfg.target_y} - {s_data.cur_y[AW-1], s_data.cur_y};

    always_comb begin
        iter_req.start = (state_reg == S_SQRT_GO) || (state_reg == S_DX_GO)
                         || (state_reg == S_DY_GO);
        iter_req.mode  = (state_reg == S_SQRT_GO) ? ITER_SQRT : ITER_DIV;
    end

    always_comb begin
        unique case (state_reg)
            S_SQX: begin
                mul_a = ax_reg;
                mul_b = SW'(ax_reg);
            end
            S_SQY: begin
                mul_a = ay_reg;
                mul_b = SW'(ay_reg);
            end
            S_MX: begin
                mul_a = ax_reg;
                mul_b = cfg.speed_q;
            end
            default: begin
                mul_a = ay_reg;
                mul_b = cfg.speed_q;
            end
        endcase
    end

    always_comb begin
        if (cfg.start_x < cfg.target_x) begin
            lox = SUM_W'(cfg.start_x);
            hix = SUM_W'(cfg.target_x);
        end else begin
            lox = SUM_W'(cfg.target_x);
            hix = SUM_W'(cfg.start_x);
        end
        if (cfg.start_y < cfg.target_y) begin
            loy = SUM_W'(cfg.start_y);
            hiy = SUM_W'(cfg.target_y);
        end else begin
            loy = SUM_W'(cfg.target_y);
            hiy = SUM_W'(cfg.start_y);
        end
        priority if (sx_reg < lox) begin
            nx = lox[AW-1:0];
        end else if (sx_reg > hix) begin
            nx = hix[AW-1:0];
        end else begin
            nx = sx_reg[AW-1:0];
        end
        priority if (sy_reg < loy) begin
            ny = loy[AW-1:0];
        end else if (sy_reg > hiy) begin
            ny = hiy[AW-1:0];
        end else begin
            ny = sy_reg[AW-1:0];
        end
    end

    always_comb begin
        out_load   = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
        ended_next = ended_reg;
        unique case (kind_reg)
            KIND_STEP: begin
                out_data.new_x    = nx;
                out_data.new_y    = ny;
                out_data.moved    = 1'b1;
                out_data.done_res = (nx == cfg.target_x) && (ny == cfg.target_y);
                ended_next        = out_data.done_res;
            end
            KIND_ZERO: begin
                out_data.new_x    = cx_reg;
                out_data.new_y    = cy_reg;
                out_data.moved    = 1'b1;
                out_data.done_res = 1'b1;
                ended_next        = 1'b1;
            end
            default: begin
                out_data.new_x    = cx_reg;
                out_data.new_y    = cy_reg;
                out_data.moved    = 1'b0;
                out_data.done_res = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = ended_reg ? S_OUT : S_SQX;
                end
            end
            S_SQX:     state_next = S_SQY;
            S_SQY:     state_next = S_SUM;
            S_SUM:     state_next = S_SQRT_GO;
            S_SQRT_GO: state_next = S_SQRT_WT;
            S_SQRT_WT: begin
                if (iter_rsp.done) begin
                    state_next = (iter_result[ROOT_W-1:0] == '0) ? S_OUT : S_MX;
                end
            end
            S_MX:      state_next = S_DX_GO;
            S_DX_GO:   state_next = S_DX_WT;
            S_DX_WT: begin
                if (iter_rsp.done) begin
                    state_next = S_MY;
                end
            end
            S_MY:      state_next = S_DY_GO;
            S_DY_GO:   state_next = S_DY_WT;
            S_DY_WT: begin
                if (iter_rsp.done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN:     state_next = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ended_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                ended_reg <= 1'b0;
            end else if (out_load) begin
                ended_reg <= ended_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a * mul_b);
        if (out_load) begin
            m_data_reg <= out_data;
        end
        unique case (state_reg)
            S_IDLE: begin
                cx_reg   <= s_data.cur_x;
                cy_reg   <= s_data.cur_y;
                negx_reg <= dx[AW];
                negy_reg <= dy[AW];
                ax_reg   <= dx[AW] ? AW'(-dx) : dx[AW-1:0];
                ay_reg   <= dy[AW] ? AW'(-dy) : dy[AW-1:0];
                kind_reg <= ended_reg ? KIND_SKIP : KIND_STEP;
            end
            S_SQY: begin
                d2_reg <= prod_reg[D2W-1:0];
            end
            S_SUM: begin
                d2_reg <= d2_reg + prod_reg[D2W-1:0];
            end
            S_SQRT_WT: begin
                if (iter_rsp.done) begin
                    dist_reg <= iter_result[ROOT_W-1:0];
                    if (iter_result[ROOT_W-1:0] == '0) begin
                        kind_reg <= KIND_ZERO;
                    end
                end
            end
            S_DX_WT: begin
                if (iter_rsp.done) begin
                    qx_reg <= iter_result[PROD_W-1:0];
                end
            end
            S_DY_WT: begin
                if (iter_rsp.done) begin
                    qy_reg <= iter_result[PROD_W-1:0];
                end
            end
            S_FIN: begin
                sx_reg <= negx_reg ? SUM_W'(cx_reg) - SUM_W'(qx_reg)
                                   : SUM_W'(cx_reg) + SUM_W'(qx_reg);
                sy_reg <= negy_reg ? SUM_W'(cy_reg) - SUM_W'(qy_reg)
                                   : SUM_W'(cy_reg) + SUM_W'(qy_reg);
            end
            default: ;
        endcase
    end

endmodule

/* bench/constant_speed_move_step_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant speed move step testbench
// Programs start, target and speed over the register port, then feeds position
// ticks and checks every result against a position predictor in the
// scoreboard. Most ticks follow closed-loop moves that feed each new position
// back as the next input. The run goes through idle and stall phases on both
// channels.
// ----------------------------------------------------------------------------
module constant_speed_move_step_tb;
    import csms_pkg::*;

    localparam int FRAC_BITS       = 8;
    localparam int MOVE_TICK_CAP   = 24;
    localparam int ITEMS_PER_PHASE = 440;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 130;
    localparam int PRINT_LIMIT     = 40;

    localparam logic [REG_IDX_WIDTH-1:0] REG_UNUSED = 3'd5;
    localparam logic [SPEED_WIDTH-1:0]   SPEED_MAX  = '1;

    class move_step_scoreboard;
        logic signed [COORD_WIDTH-1:0] start_x, start_y, target_x, target_y;
        logic [SPEED_WIDTH-1:0] speed_q;
        bit arrived;
        csms_out_t expected_steps[$];
        csms_out_t last_step;
        int errors;

        function new();
            start_x  = '0;
            start_y  = '0;
            target_x = '0;
            target_y = '0;
            speed_q  = SPEED_RESET;
            arrived  = 1'b0;
            errors   = 0;
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) begin
                $display("mismatch at %0t ns: %s", $realtime, msg);
            end
            errors++;
        endtask

        function void write_reg(logic [REG_IDX_WIDTH-1:0] idx, logic [31:0] value);
            case (idx)
                REG_START_X: start_x = value[COORD_WIDTH-1:0];
                REG_START_Y: start_y = value[COORD_WIDTH-1:0];
                REG_TARGET_X: target_x = value[COORD_WIDTH-1:0];
                REG_TARGET_Y: target_y = value[COORD_WIDTH-1:0];
                REG_SPEED_Q: speed_q = value[SPEED_WIDTH-1:0];
                default: ;
            endcase
            arrived = 1'b0;
        endfunction

        function logic [31:0] reg_value(logic [REG_IDX_WIDTH-1:0] idx);
            case (idx)
                REG_START_X: return 32'(start_x);
                REG_START_Y: return 32'(start_y);
                REG_TARGET_X: return 32'(target_x);
                REG_TARGET_Y: return 32'(target_y);
                REG_SPEED_Q: return 32'(speed_q);
                default: return '0;
            endcase
        endfunction

        function longint unsigned distance_root(longint unsigned n);
            longint unsigned r, c;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= n) r = c;
            end
            return r;
        endfunction

        function longint axis_advance(longint pos, longint d, longint unsigned span);
            longint unsigned mag, st;
            mag = (d < 0) ? -d : d;
            st = mag * speed_q / span;
            return (d < 0) ? pos - longint'(st) : pos + longint'(st);
        endfunction

        function longint clamp_axis(longint v, longint a, longint b);
            longint lo, hi;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function csms_out_t next_position(csms_in_t pos);
            longint cx, cy, dx, dy, nx, ny;
            longint unsigned ax, ay, span;
            csms_out_t r;
            cx = $signed(pos.cur_x);
            cy = $signed(pos.cur_y);
            nx = cx;
            ny = cy;
            r.moved = 1'b0;
            if (!arrived) begin
                dx = longint'(target_x) - cx;
                dy = longint'(target_y) - cy;
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                span = distance_root((ax * ax + ay * ay) << (2 * FRAC_BITS));
                r.moved = 1'b1;
                if (span == 0) begin
                    arrived = 1'b1;
                end else begin
                    nx = clamp_axis(axis_advance(cx, dx, span), start_x, target_x);
                    ny = clamp_axis(axis_advance(cy, dy, span), start_y, target_y);
                    if (nx == target_x && ny == target_y) arrived = 1'b1;
                end
            end
            r.new_x = nx[COORD_WIDTH-1:0];
            r.new_y = ny[COORD_WIDTH-1:0];
            r.done_res = arrived;
            return r;
        endfunction

        function void note_tick(csms_in_t pos);
            expected_steps.push_back(next_position(pos));
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        task check_step(csms_out_t got);
            csms_out_t want;
            last_step = got;
            if (expected_steps.size() == 0) begin
                report("result with no transaction outstanding");
                return;
            end
            want = expected_steps.pop_front();
            if (got.new_x !== want.new_x)
                report($sformatf("new_x got %0d want %0d",
                                 $signed(got.new_x), $signed(want.new_x)));
            if (got.new_y !== want.new_y)
                report($sformatf("new_y got %0d want %0d",
                                 $signed(got.new_y), $signed(want.new_y)));
            if (got.moved !== want.moved)
                report($sformatf("moved got %b want %b", got.moved, want.moved));
            if (got.done_res !== want.done_res)
                report($sformatf("done_res got %b want %b", got.done_res, want.done_res));
        endtask
    endclass

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    csms_in_t                  s_data  = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    csms_out_t                 m_data;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr   = '0;
    logic [APB_DATA_WIDTH-1:0] pwdata  = '0;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    move_step_scoreboard sb;
    int idle_pct  = 0;
    int stall_pct = 0;
    int items_sent = 0;

    constant_speed_move_step #(
        .SPEED_FRAC_BITS(FRAC_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #6_000_000;
        $display("constant_speed_move_step_tb NOT OK");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_step(m_data);
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic tick(input int x, input int y);
        csms_in_t pos;
        pos.cur_x = x[COORD_WIDTH-1:0];
        pos.cur_y = y[COORD_WIDTH-1:0];
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= pos;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(pos);
        items_sent++;
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [REG_IDX_WIDTH-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic apb_check(input logic [REG_IDX_WIDTH-1:0] idx);
        logic [31:0] got, want, mask;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        mask = (idx == REG_SPEED_Q) ? 32'(SPEED_MAX) : 32'hFFFF;
        want = sb.reg_value(idx);
        if ((got & mask) !== (want & mask))
            sb.report($sformatf("register %0d read %h want %h", idx, got & mask, want & mask));
    endtask

    task automatic program_move(input int sx, input int sy, input int tx, input int ty,
                                input logic [SPEED_WIDTH-1:0] speed, input bit readback);
        settle();
        apb_write(REG_START_X, 32'(sx));
        apb_write(REG_START_Y, 32'(sy));
        apb_write(REG_TARGET_X, 32'(tx));
        apb_write(REG_TARGET_Y, 32'(ty));
        apb_write(REG_SPEED_Q, 32'(speed));
        if (readback) begin
            for (int i = 0; i <= int'(REG_SPEED_Q); i++) apb_check(REG_IDX_WIDTH'(i));
        end
    endtask

    function automatic int rand_coord();
        int w;
        if ($urandom_range(9) == 0) return $urandom_range(1) ? 32767 : -32768;
        w = $urandom_range(1, 16);
        return int'($urandom_range(0, (1 << w) - 1)) - (1 << (w - 1));
    endfunction

    function automatic int fit_coord(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic run_directed();
        settle();
        tick(0, 0);
        tick(-32768, 32767);
        settle();
        apb_write(REG_UNUSED, 32'h0000_0000);
        tick(5, -3);
        program_move(-32768, -32768, 32767, 32767, SPEED_MAX, 1'b1);
        tick(-32768, -32768);
        tick(0, 0);
        program_move(32767, -32768, -32768, 32767, 24'd1, 1'b0);
        tick(32767, -32768);
        tick(-32768, 32767);
        program_move(0, 0, 10, 10, 24'd0, 1'b1);
        tick(3, 4);
        tick(20, 5);
        tick(-7, 40);
        tick(10, 10);
        program_move(100, -50, -20, 30, 24'd1280, 1'b0);
        tick(100, -50);
        tick(-300, 300);
        tick(32767, -32768);
        tick(0, 0);
    endtask

    task automatic run_move();
        int sx, sy, tx, ty, x, y;
        longint ax, ay, est, sp;
        bit finished;
        sx = rand_coord();
        sy = rand_coord();
        tx = rand_coord();
        ty = rand_coord();
        ax = (tx > sx) ? tx - sx : sx - tx;
        ay = (ty > sy) ? ty - sy : sy - ty;
        est = (ax > ay) ? ax + ay / 2 : ay + ax / 2;
        sp = (est << FRAC_BITS) / $urandom_range(1, 16);
        sp = sp * $urandom_range(60, 140) / 100;
        case ($urandom_range(19))
            0: sp = 0;
            1: sp = $urandom_range(1, 255);
            2: sp = $urandom_range(0, SPEED_MAX);
            default: ;
        endcase
        if (sp > SPEED_MAX) sp = SPEED_MAX;
        program_move(sx, sy, tx, ty, sp[SPEED_WIDTH-1:0], $urandom_range(3) == 0);
        case ($urandom_range(19))
            0, 1, 2: begin
                x = rand_coord();
                y = rand_coord();
            end
            3, 4: begin
                x = tx;
                y = ty;
            end
            default: begin
                x = sx;
                y = sy;
            end
        endcase
        finished = 1'b0;
        for (int k = 0; k < MOVE_TICK_CAP && !finished; k++) begin
            tick(x, y);
            wait_results();
            finished = sb.last_step.done_res;
            x = $signed(sb.last_step.new_x);
            y = $signed(sb.last_step.new_y);
            if ($urandom_range(99) < 12) begin
                x = fit_coord(x + int'($urandom_range(6)) - 3);
                y = fit_coord(y + int'($urandom_range(6)) - 3);
            end
        end
        if (finished) begin
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(1)) begin
                    x = rand_coord();
                    y = rand_coord();
                end
                tick(x, y);
            end
        end
    endtask

    task automatic run_noise();
        settle();
        repeat ($urandom_range(1, 3)) apb_write(REG_IDX_WIDTH'($urandom_range(7)), $urandom());
        repeat ($urandom_range(1, 4)) tick(rand_coord(), rand_coord());
    endtask

    initial begin
        int phase_start;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 59;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 59;
                end
                default: begin
                    idle_pct  = 10;
                    stall_pct = 10;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 85) run_move();
                else run_noise();
            end
        end
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("constant_speed_move_step_tb OK");
        end else begin
            $display("constant_speed_move_step_tb NOT OK");
        end
        $finish;
    end

endmodule

/* constant_speed_move_step.f */
hw/rtl/csms_pkg.sv
hw/rtl/csms_cfg.sv
hw/rtl/csms_iter.sv
hw/rtl/constant_speed_move_step.sv
bench/constant_speed_move_step_tb.sv
